// ===== rtl/core/fpp_pkg.sv =====
// Shared types and constants for the FEN position parser.
`timescale 1ns / 1ps

package fpp_pkg;

  // Character codes the parser looks for
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_H  = 8'h68;
  localparam logic [7:0] CH_LO_K  = 8'h6B;
  localparam logic [7:0] CH_LO_N  = 8'h6E;
  localparam logic [7:0] CH_LO_P  = 8'h70;
  localparam logic [7:0] CH_LO_Q  = 8'h71;
  localparam logic [7:0] CH_LO_R  = 8'h72;
  localparam logic [7:0] CH_LO_W  = 8'h77;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // Board geometry
  localparam logic [3:0] FILES_PER_RANK = 4'd8;
  localparam logic [2:0] TOP_RANK       = 3'd7;
  localparam logic [2:0] FILE_A         = 3'd0;
  localparam logic [2:0] FILE_H         = 3'd7;

  // Piece kinds
  localparam logic [2:0] PK_PAWN   = 3'd0;
  localparam logic [2:0] PK_KNIGHT = 3'd1;
  localparam logic [2:0] PK_BISHOP = 3'd2;
  localparam logic [2:0] PK_ROOK   = 3'd3;
  localparam logic [2:0] PK_QUEEN  = 3'd4;
  localparam logic [2:0] PK_KING   = 3'd5;

  // Outcome status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EOF    = 3'd1;
  localparam logic [2:0] ST_CASTLE = 3'd2;
  localparam logic [2:0] ST_FILES  = 3'd3;
  localparam logic [2:0] ST_EP     = 3'd4;
  localparam logic [2:0] ST_PIECE  = 3'd5;
  localparam logic [2:0] ST_SIDE   = 3'd6;

  // Result kinds
  localparam logic KIND_PLACE   = 1'b0;
  localparam logic KIND_OUTCOME = 1'b1;

  // One input byte
  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } byte_item_t;

  // One result
  typedef struct packed {
    logic       kind;
    logic [5:0] square;
    logic       piece_black;
    logic [2:0] piece_type;
    logic [2:0] status;
    logic       black_to_move;
    logic [3:0] castle_bits;
    logic [2:0] rook_file_a;
    logic [2:0] rook_file_h;
    logic       ep_valid;
    logic [2:0] ep_file;
  } result_item_t;

  // Classified byte passed from the front to the back
  typedef struct packed {
    logic       first;
    logic       nul;
    logic       space;
    logic       digit;
    logic [3:0] digit_val;
    logic       letter;
    logic       piece_ok;
    logic [2:0] piece_type;
    logic       black;
    logic       slash;
    logic       dash;
    logic       lc_w;
    logic       lc_b;
    logic       lc_k;
    logic       lc_q;
    logic       cfile_ok;
    logic       epfile_ok;
    logic [2:0] file;
    logic       rank_ok;
  } token_t;

endpackage

// ===== rtl/core/fpp_front.sv =====
// Front end: accepts bytes and classifies each into a token.
`timescale 1ns / 1ps

module fpp_front (
  input  logic                byte_valid,
  output logic                byte_stall,
  input  fpp_pkg::byte_item_t byte_item,
  output logic                push,
  output fpp_pkg::token_t     token,
  input  logic                full
);

  logic [7:0] c;
  logic [7:0] lc;
  logic [7:0] lc_off;
  logic       upper;
  logic       lower;

  assign c      = byte_item.ch;
  assign upper  = (c >= fpp_pkg::CH_UP_A) && (c <= fpp_pkg::CH_UP_Z);
  assign lower  = (c >= fpp_pkg::CH_LO_A) && (c <= fpp_pkg::CH_LO_Z);
  assign lc     = upper ? (c | fpp_pkg::CASE_BIT) : c;
  assign lc_off = lc - fpp_pkg::CH_LO_A;

  // Hold the byte while the queue is full
  assign byte_stall = full;
  assign push       = byte_valid && !full;

  // Classify the byte
  always_comb begin
    token            = '0;
    token.first      = byte_item.first;
    token.nul        = (c == fpp_pkg::CH_NUL);
    token.space      = (c == fpp_pkg::CH_SPACE) ||
                       ((c >= fpp_pkg::CH_TAB) && (c <= fpp_pkg::CH_CR));
    token.digit      = (c >= fpp_pkg::CH_ZERO) && (c <= fpp_pkg::CH_NINE);
    token.digit_val  = c[3:0];
    token.letter     = upper || lower;
    token.black      = lower;
    token.slash      = (c == fpp_pkg::CH_SLASH);
    token.dash       = (c == fpp_pkg::CH_DASH);
    token.lc_w       = (lc == fpp_pkg::CH_LO_W);
    token.lc_b       = (lc == fpp_pkg::CH_LO_B);
    token.lc_k       = (lc == fpp_pkg::CH_LO_K);
    token.lc_q       = (lc == fpp_pkg::CH_LO_Q);
    token.cfile_ok   = (lc >= fpp_pkg::CH_LO_A) && (lc <= fpp_pkg::CH_LO_H);
    token.epfile_ok  = (c >= fpp_pkg::CH_LO_A) && (c <= fpp_pkg::CH_LO_H);
    token.file       = lc_off[2:0];
    token.rank_ok    = (c >= fpp_pkg::CH_ONE) && (c <= fpp_pkg::CH_EIGHT);
    token.piece_ok   = 1'b1;
    unique case (lc)
      fpp_pkg::CH_LO_P: token.piece_type = fpp_pkg::PK_PAWN;
      fpp_pkg::CH_LO_N: token.piece_type = fpp_pkg::PK_KNIGHT;
      fpp_pkg::CH_LO_B: token.piece_type = fpp_pkg::PK_BISHOP;
      fpp_pkg::CH_LO_R: token.piece_type = fpp_pkg::PK_ROOK;
      fpp_pkg::CH_LO_Q: token.piece_type = fpp_pkg::PK_QUEEN;
      fpp_pkg::CH_LO_K: token.piece_type = fpp_pkg::PK_KING;
      default: begin
        token.piece_type = fpp_pkg::PK_PAWN;
        token.piece_ok   = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/fpp_queue.sv =====
// Two-entry token queue between the front and the back.
`timescale 1ns / 1ps

module fpp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fpp_pkg::token_t push_token,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output fpp_pkg::token_t head
);

  fpp_pkg::token_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  // Store the pushed token
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_token;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/fpp_back.sv =====
// Back end: parse state machine and result register.
`timescale 1ns / 1ps

module fpp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  fpp_pkg::token_t       head,
  output logic                  pop,
  output logic                  result_valid,
  input  logic                  result_stall,
  output fpp_pkg::result_item_t result_item
);

  localparam logic [3:0] PH_IDLE          = 4'd0;
  localparam logic [3:0] PH_RANKS         = 4'd1;
  localparam logic [3:0] PH_SIDE          = 4'd2;
  localparam logic [3:0] PH_CASTLE_START  = 4'd3;
  localparam logic [3:0] PH_CASTLE_FIRST  = 4'd4;
  localparam logic [3:0] PH_CASTLE_SECOND = 4'd5;
  localparam logic [3:0] PH_EP_START      = 4'd6;
  localparam logic [3:0] PH_EP_RANK       = 4'd7;
  localparam logic [3:0] PH_DONE          = 4'd8;

  // Parse state
  logic [3:0] phase;
  logic [2:0] rank_index;
  logic [3:0] file_count;
  logic       side_reg;
  logic [3:0] castle_reg;
  logic       black_half;
  logic       wide_style;
  logic [2:0] hfile;
  logic [2:0] rook_a;
  logic [2:0] rook_h;
  logic [2:0] ep_file_reg;

  // State after a restart, if any
  logic [3:0] ph_e;
  logic [2:0] rank_e;
  logic [3:0] fc_e;
  logic       side_e;
  logic [3:0] castle_e;
  logic       bh_e;
  logic       wide_e;
  logic [2:0] hfile_e;
  logic [2:0] rook_a_e;
  logic [2:0] rook_h_e;
  logic [2:0] ep_e;

  logic [3:0] phase_next;
  logic [2:0] rank_next;
  logic [3:0] fc_next;
  logic       side_next;
  logic [3:0] castle_next;
  logic       bh_next;
  logic       wide_next;
  logic [2:0] hfile_next;
  logic [2:0] rook_a_next;
  logic [2:0] rook_h_next;
  logic [2:0] ep_next;

  logic                  emit;
  fpp_pkg::result_item_t res;
  logic                  fin;
  logic [2:0]            fin_status;
  logic                  fin_ep;
  logic                  run_side;
  logic                  run_cfirst;
  logic                  bh_cur;
  logic [3:0]            hbit;
  logic [3:0]            abit;
  logic [4:0]            fsum;
  logic                  afile_given;

  assign pop = head_valid && (!result_valid || !result_stall);

  // Apply a restart before the byte is parsed
  always_comb begin
    if (head.first) begin
      ph_e     = PH_RANKS;
      rank_e   = fpp_pkg::TOP_RANK;
      fc_e     = 4'd0;
      side_e   = 1'b0;
      castle_e = 4'd0;
      bh_e     = 1'b0;
      wide_e   = 1'b0;
      hfile_e  = fpp_pkg::FILE_A;
      rook_a_e = fpp_pkg::FILE_A;
      rook_h_e = fpp_pkg::FILE_H;
      ep_e     = fpp_pkg::FILE_A;
    end else begin
      ph_e     = phase;
      rank_e   = rank_index;
      fc_e     = file_count;
      side_e   = side_reg;
      castle_e = castle_reg;
      bh_e     = black_half;
      wide_e   = wide_style;
      hfile_e  = hfile;
      rook_a_e = rook_a;
      rook_h_e = rook_h;
      ep_e     = ep_file_reg;
    end
  end

  assign fsum = {1'b0, fc_e} + {1'b0, head.digit_val};

  // Parse one token
  always_comb begin
    phase_next  = ph_e;
    rank_next   = rank_e;
    fc_next     = fc_e;
    side_next   = side_e;
    castle_next = castle_e;
    bh_next     = bh_e;
    wide_next   = wide_e;
    hfile_next  = hfile_e;
    rook_a_next = rook_a_e;
    rook_h_next = rook_h_e;
    ep_next     = ep_e;
    emit        = 1'b0;
    res         = '0;
    fin         = 1'b0;
    fin_status  = fpp_pkg::ST_OK;
    fin_ep      = 1'b0;
    run_side    = 1'b0;
    run_cfirst  = 1'b0;
    afile_given = 1'b0;
    bh_cur      = (ph_e == PH_CASTLE_START) ? 1'b0 : bh_e;
    hbit        = bh_cur ? 4'b0100 : 4'b0001;
    abit        = bh_cur ? 4'b1000 : 4'b0010;

    unique case (ph_e)
      PH_RANKS: begin
        if (head.digit) begin
          if (fsum > {1'b0, fpp_pkg::FILES_PER_RANK}) begin
            fin        = 1'b1;
            fin_status = fpp_pkg::ST_FILES;
          end else begin
            fc_next = fsum[3:0];
          end
        end else if (head.letter) begin
          if (!head.piece_ok) begin
            fin        = 1'b1;
            fin_status = fpp_pkg::ST_PIECE;
          end else if (fc_e >= fpp_pkg::FILES_PER_RANK) begin
            fin        = 1'b1;
            fin_status = fpp_pkg::ST_FILES;
          end else begin
            emit            = 1'b1;
            res.kind        = fpp_pkg::KIND_PLACE;
            res.square      = {rank_e, fc_e[2:0]};
            res.piece_black = head.black;
            res.piece_type  = head.piece_type;
            fc_next         = fc_e + 4'd1;
          end
        end else if (head.slash) begin
          if (fc_e != fpp_pkg::FILES_PER_RANK) begin
            fin        = 1'b1;
            fin_status = fpp_pkg::ST_FILES;
          end else begin
            fc_next = 4'd0;
            if (rank_e == 3'd0) begin
              phase_next = PH_SIDE;
            end else begin
              rank_next = rank_e - 3'd1;
            end
          end
        end else if ((fc_e == fpp_pkg::FILES_PER_RANK) && (rank_e == 3'd0)) begin
          phase_next = PH_SIDE;
          run_side   = 1'b1;
        end else begin
          fin        = 1'b1;
          fin_status = head.nul ? fpp_pkg::ST_EOF : fpp_pkg::ST_PIECE;
        end
      end
      PH_SIDE: begin
        run_side = 1'b1;
      end
      PH_CASTLE_START: begin
        if (head.space) begin
          phase_next = ph_e;
        end else if (head.dash) begin
          castle_next = 4'd0;
          phase_next  = PH_EP_START;
        end else begin
          bh_next    = 1'b0;
          run_cfirst = 1'b1;
        end
      end
      PH_CASTLE_FIRST: begin
        run_cfirst = 1'b1;
      end
      PH_CASTLE_SECOND: begin
        if (head.lc_q) begin
          if (wide_e) begin
            fin        = 1'b1;
            fin_status = fpp_pkg::ST_CASTLE;
          end else begin
            castle_next = castle_e | abit;
          end
        end else if (head.dash) begin
          castle_next = castle_e & ~abit;
        end else if (!head.cfile_ok) begin
          fin        = 1'b1;
          fin_status = fpp_pkg::ST_CASTLE;
        end else begin
          afile_given = 1'b1;
          castle_next = castle_e | abit;
        end
        if (!fin) begin
          // Load rook files from this half
          if (wide_e && afile_given) begin
            rook_h_next = hfile_e;
            rook_a_next = head.file;
          end else begin
            rook_h_next = fpp_pkg::FILE_H;
            rook_a_next = fpp_pkg::FILE_A;
          end
          if (bh_e) begin
            phase_next = PH_EP_START;
          end else begin
            bh_next    = 1'b1;
            phase_next = PH_CASTLE_FIRST;
          end
        end
      end
      PH_EP_START: begin
        if (head.space) begin
          phase_next = ph_e;
        end else if (head.dash || head.nul) begin
          fin = 1'b1;
        end else if (!head.epfile_ok) begin
          fin        = 1'b1;
          fin_status = fpp_pkg::ST_EP;
        end else begin
          ep_next    = head.file;
          phase_next = PH_EP_RANK;
        end
      end
      PH_EP_RANK: begin
        fin = 1'b1;
        if (head.rank_ok) begin
          fin_ep = 1'b1;
        end else begin
          fin_status = fpp_pkg::ST_EP;
        end
      end
      default: begin
        phase_next = ph_e;
      end
    endcase

    // Side to move
    if (run_side) begin
      if (head.space) begin
        phase_next = PH_SIDE;
      end else if (head.lc_w || head.lc_b) begin
        side_next  = head.lc_b;
        phase_next = PH_CASTLE_START;
      end else begin
        fin        = 1'b1;
        fin_status = head.nul ? fpp_pkg::ST_EOF : fpp_pkg::ST_SIDE;
      end
    end

    // First character of a castling half
    if (run_cfirst) begin
      if (head.lc_k) begin
        wide_next   = 1'b0;
        castle_next = castle_e | hbit;
        phase_next  = PH_CASTLE_SECOND;
      end else if (head.dash) begin
        wide_next   = 1'b0;
        castle_next = castle_e & ~hbit;
        phase_next  = PH_CASTLE_SECOND;
      end else if (head.nul) begin
        fin        = 1'b1;
        fin_status = fpp_pkg::ST_EOF;
      end else if (!head.cfile_ok) begin
        fin        = 1'b1;
        fin_status = fpp_pkg::ST_CASTLE;
      end else begin
        wide_next   = 1'b1;
        hfile_next  = head.file;
        castle_next = castle_e | hbit;
        phase_next  = PH_CASTLE_SECOND;
      end
    end

    // Build the outcome and stop parsing
    if (fin) begin
      emit              = 1'b1;
      res               = '0;
      res.kind          = fpp_pkg::KIND_OUTCOME;
      res.status        = fin_status;
      res.black_to_move = side_e;
      res.castle_bits   = castle_e;
      res.rook_file_a   = rook_a_e;
      res.rook_file_h   = rook_h_e;
      res.ep_valid      = fin_ep;
      res.ep_file       = fin_ep ? ep_e : fpp_pkg::FILE_A;
      phase_next        = PH_DONE;
    end
  end

  // Update state when a token is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      rank_index  <= fpp_pkg::TOP_RANK;
      file_count  <= 4'd0;
      side_reg    <= 1'b0;
      castle_reg  <= 4'd0;
      black_half  <= 1'b0;
      wide_style  <= 1'b0;
      hfile       <= fpp_pkg::FILE_A;
      rook_a      <= fpp_pkg::FILE_A;
      rook_h      <= fpp_pkg::FILE_H;
      ep_file_reg <= fpp_pkg::FILE_A;
    end else if (pop) begin
      phase       <= phase_next;
      rank_index  <= rank_next;
      file_count  <= fc_next;
      side_reg    <= side_next;
      castle_reg  <= castle_next;
      black_half  <= bh_next;
      wide_style  <= wide_next;
      hfile       <= hfile_next;
      rook_a      <= rook_a_next;
      rook_h      <= rook_h_next;
      ep_file_reg <= ep_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= emit;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      result_item <= res;
    end
  end

endmodule

// ===== rtl/core/fen_position_parser_core.sv =====
// Top level of the FEN position parser: front, queue and back.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+--------------------------------
//   bytes    | byte_valid / byte_stall    | byte_item   (ch, first)
//   results  | result_valid / result_stall| result_item (placement or outcome)
//
// One byte is taken per cycle while the queue has room; its result, if any,
// appears in the cycle after the back end takes it from the two-entry queue.
// The combinational parse step sets the rate: one byte per cycle unless stalled.
// Reset (rst, synchronous) empties the queue and result register and leaves
// the parser idle until a byte marked first arrives.
// A stalled result holds the back end; bytes keep entering until the queue fills.
`timescale 1ns / 1ps

module fen_position_parser_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  fpp_pkg::byte_item_t   byte_item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output fpp_pkg::result_item_t result_item
);

  logic            push;
  logic            full;
  logic            pop;
  logic            head_valid;
  fpp_pkg::token_t push_token;
  fpp_pkg::token_t head;

  fpp_front u_front (
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .push       (push),
    .token      (push_token),
    .full       (full)
  );

  fpp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  fpp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

// ===== verif/fen_position_parser_core_test.sv =====
// Self-checking testbench for the FEN position parser core.
`timescale 1ns / 1ps

module fen_position_parser_core_test;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_BYTES = 1000;

  // Castling right bits
  localparam logic [3:0] CB_WHITE_H = 4'b0001;
  localparam logic [3:0] CB_WHITE_A = 4'b0010;
  localparam logic [3:0] CB_BLACK_H = 4'b0100;
  localparam logic [3:0] CB_BLACK_A = 4'b1000;

  typedef enum logic [3:0] {
    P_IDLE, P_RANKS, P_SIDE, P_CASTLE_OPEN, P_CASTLE_HSIDE, P_CASTLE_ASIDE,
    P_EP_FILE, P_EP_RANK, P_DONE
  } parse_phase_t;

  logic                  clk;
  logic                  rst;
  logic                  byte_valid;
  logic                  byte_stall;
  fpp_pkg::byte_item_t   byte_item;
  logic                  result_valid;
  logic                  result_stall;
  fpp_pkg::result_item_t result_item;

  // Mirror of the parser state
  parse_phase_t pp_phase;
  logic [2:0]   rank_ix;
  int           files_used;
  logic         side_black;
  logic [3:0]   castle_q;
  logic         black_half;
  logic         file_letters;
  logic [3:0]   pending_hfile;
  logic [2:0]   rook_a;
  logic [2:0]   rook_h;
  logic [2:0]   ep_col;

  fpp_pkg::result_item_t predicted_reports[$];
  int errors = 0;
  int bytes_sent = 0;
  int strings_sent = 0;
  int placements_seen = 0;
  int outcomes_seen = 0;
  int cycle_count = 0;
  bit idle_on = 1'b1;

  fen_position_parser_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout with %0d results outstanding", $time, predicted_reports.size());
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Parser prediction

  function automatic logic [7:0] lower_of(input logic [7:0] c);
    return (c >= fpp_pkg::CH_UP_A && c <= fpp_pkg::CH_UP_Z) ? (c | fpp_pkg::CASE_BIT) : c;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == fpp_pkg::CH_SPACE || (c >= fpp_pkg::CH_TAB && c <= fpp_pkg::CH_CR);
  endfunction

  task automatic start_position();
    rank_ix       = fpp_pkg::TOP_RANK;
    files_used    = 0;
    side_black    = 1'b0;
    castle_q      = '0;
    black_half    = 1'b0;
    file_letters  = 1'b0;
    pending_hfile = 4'd8;
    rook_a        = fpp_pkg::FILE_A;
    rook_h        = fpp_pkg::FILE_H;
    ep_col        = '0;
  endtask

  task automatic close_parse(input logic [2:0] st, input logic with_ep);
    fpp_pkg::result_item_t r;
    r = '0;
    r.kind          = fpp_pkg::KIND_OUTCOME;
    r.status        = st;
    r.black_to_move = side_black;
    r.castle_bits   = castle_q;
    r.rook_file_a   = rook_a;
    r.rook_file_h   = rook_h;
    r.ep_valid      = with_ep;
    r.ep_file       = with_ep ? ep_col : 3'd0;
    predicted_reports.push_back(r);
    pp_phase = P_DONE;
  endtask

  task automatic side_step(input logic [7:0] c);
    logic [7:0] lc;
    lc = lower_of(c);
    if (!is_blank(c)) begin
      if (lc == fpp_pkg::CH_LO_W || lc == fpp_pkg::CH_LO_B) begin
        side_black = (lc == fpp_pkg::CH_LO_B);
        pp_phase = P_CASTLE_OPEN;
      end else begin
        close_parse((c == fpp_pkg::CH_NUL) ? fpp_pkg::ST_EOF : fpp_pkg::ST_SIDE, 1'b0);
      end
    end
  endtask

  task automatic rank_step(input logic [7:0] c);
    logic [7:0] lc;
    logic [2:0] kind_code;
    fpp_pkg::result_item_t place;
    int sum;
    lc = lower_of(c);
    if (c >= fpp_pkg::CH_ZERO && c <= fpp_pkg::CH_NINE) begin
      // skip files, flag an overfull rank
      sum = files_used + int'(c) - int'(fpp_pkg::CH_ZERO);
      if (sum > 8) close_parse(fpp_pkg::ST_FILES, 1'b0);
      else files_used = sum;
    end else if ((c >= fpp_pkg::CH_UP_A && c <= fpp_pkg::CH_UP_Z) ||
                 (c >= fpp_pkg::CH_LO_A && c <= fpp_pkg::CH_LO_Z)) begin
      case (lc)
        fpp_pkg::CH_LO_P: kind_code = fpp_pkg::PK_PAWN;
        fpp_pkg::CH_LO_N: kind_code = fpp_pkg::PK_KNIGHT;
        fpp_pkg::CH_LO_B: kind_code = fpp_pkg::PK_BISHOP;
        fpp_pkg::CH_LO_R: kind_code = fpp_pkg::PK_ROOK;
        fpp_pkg::CH_LO_Q: kind_code = fpp_pkg::PK_QUEEN;
        fpp_pkg::CH_LO_K: kind_code = fpp_pkg::PK_KING;
        default: begin
          close_parse(fpp_pkg::ST_PIECE, 1'b0);
          return;
        end
      endcase
      // a piece past file eight places nothing
      if (files_used >= 8) begin
        close_parse(fpp_pkg::ST_FILES, 1'b0);
        return;
      end
      place = '0;
      place.kind        = fpp_pkg::KIND_PLACE;
      place.square      = {rank_ix, files_used[2:0]};
      place.piece_black = (c >= fpp_pkg::CH_LO_A);
      place.piece_type  = kind_code;
      predicted_reports.push_back(place);
      files_used++;
    end else if (c == fpp_pkg::CH_SLASH) begin
      if (files_used != 8) begin
        close_parse(fpp_pkg::ST_FILES, 1'b0);
      end else begin
        files_used = 0;
        if (rank_ix == 3'd0) pp_phase = P_SIDE;
        else rank_ix--;
      end
    end else if (files_used == 8 && rank_ix == 3'd0) begin
      // full last rank: hand the byte to the side field
      pp_phase = P_SIDE;
      side_step(c);
    end else begin
      close_parse((c == fpp_pkg::CH_NUL) ? fpp_pkg::ST_EOF : fpp_pkg::ST_PIECE, 1'b0);
    end
  endtask

  task automatic castle_hside(input logic [7:0] c);
    logic [7:0] lc;
    logic [7:0] f;
    logic [3:0] hbit;
    lc = lower_of(c);
    f = lc - fpp_pkg::CH_LO_A;
    hbit = black_half ? CB_BLACK_H : CB_WHITE_H;
    if (lc == fpp_pkg::CH_LO_K) begin
      file_letters = 1'b0;
      castle_q |= hbit;
    end else if (lc == fpp_pkg::CH_DASH) begin
      file_letters = 1'b0;
      castle_q &= ~hbit;
    end else if (c == fpp_pkg::CH_NUL) begin
      close_parse(fpp_pkg::ST_EOF, 1'b0);
      return;
    end else if (f > 7) begin
      close_parse(fpp_pkg::ST_CASTLE, 1'b0);
      return;
    end else begin
      file_letters = 1'b1;
      pending_hfile = {1'b0, f[2:0]};
      castle_q |= hbit;
    end
    pp_phase = P_CASTLE_ASIDE;
  endtask

  task automatic castle_aside(input logic [7:0] c);
    logic [7:0] lc;
    logic [7:0] f;
    logic [3:0] abit;
    bit afile_given;
    lc = lower_of(c);
    f = lc - fpp_pkg::CH_LO_A;
    abit = black_half ? CB_BLACK_A : CB_WHITE_A;
    afile_given = 1'b0;
    if (lc == fpp_pkg::CH_LO_Q) begin
      if (file_letters) begin
        close_parse(fpp_pkg::ST_CASTLE, 1'b0);
        return;
      end
      castle_q |= abit;
    end else if (lc == fpp_pkg::CH_DASH) begin
      castle_q &= ~abit;
    end else if (f > 7) begin
      close_parse(fpp_pkg::ST_CASTLE, 1'b0);
      return;
    end else begin
      afile_given = 1'b1;
      castle_q |= abit;
    end
    // each half reloads the rook files; only letters on both sides keep them
    if (file_letters && afile_given) begin
      rook_h = pending_hfile[2:0];
      rook_a = f[2:0];
    end else begin
      rook_a = fpp_pkg::FILE_A;
      rook_h = fpp_pkg::FILE_H;
    end
    if (black_half) begin
      pp_phase = P_EP_FILE;
    end else begin
      black_half = 1'b1;
      pp_phase = P_CASTLE_HSIDE;
    end
  endtask

  task automatic parse_fen_byte(input fpp_pkg::byte_item_t b);
    logic [7:0] c;
    logic [7:0] f;
    c = b.ch;
    if (b.first) begin
      start_position();
      pp_phase = P_RANKS;
    end
    case (pp_phase)
      P_RANKS:        rank_step(c);
      P_SIDE:         side_step(c);
      P_CASTLE_HSIDE: castle_hside(c);
      P_CASTLE_ASIDE: castle_aside(c);
      P_CASTLE_OPEN: begin
        if (!is_blank(c)) begin
          if (c == fpp_pkg::CH_DASH) begin
            castle_q = '0;
            pp_phase = P_EP_FILE;
          end else begin
            black_half = 1'b0;
            castle_hside(c);
          end
        end
      end
      P_EP_FILE: begin
        f = c - fpp_pkg::CH_LO_A;
        if (!is_blank(c)) begin
          if (c == fpp_pkg::CH_DASH || c == fpp_pkg::CH_NUL) close_parse(fpp_pkg::ST_OK, 1'b0);
          else if (f > 7) close_parse(fpp_pkg::ST_EP, 1'b0);
          else begin
            ep_col = f[2:0];
            pp_phase = P_EP_RANK;
          end
        end
      end
      P_EP_RANK: begin
        f = c - fpp_pkg::CH_ONE;
        close_parse((f > 7) ? fpp_pkg::ST_EP : fpp_pkg::ST_OK, f <= 7);
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driving and checking

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic send_byte(input logic [7:0] ch, input logic first);
    fpp_pkg::byte_item_t b;
    int gap;
    b.ch = ch;
    b.first = first;
    gap = idle_on ? pick_gap() : 0;
    // idle the byte channel, then offer the item
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= b;
    // hold until the next edge accepts it
    do @(negedge clk); while (byte_stall !== 1'b0);
    @(posedge clk);
    if (first || (pp_phase != P_IDLE && pp_phase != P_DONE)) bytes_sent++;
    parse_fen_byte(b);
  endtask

  task automatic send_text(input string s, input bit nul_end);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], i == 0);
    if (nul_end) send_byte(fpp_pkg::CH_NUL, 1'b0);
    strings_sent++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      errors++;
    end
  endtask

  task automatic check_result(input fpp_pkg::result_item_t got);
    fpp_pkg::result_item_t want;
    if (predicted_reports.size() == 0) begin
      $display("%0t: result with none expected, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = predicted_reports.pop_front();
    if (want.kind == fpp_pkg::KIND_OUTCOME) outcomes_seen++;
    else placements_seen++;
    compare_field("kind", 8'(want.kind), 8'(got.kind));
    compare_field("square", 8'(want.square), 8'(got.square));
    compare_field("piece_black", 8'(want.piece_black), 8'(got.piece_black));
    compare_field("piece_type", 8'(want.piece_type), 8'(got.piece_type));
    compare_field("status", 8'(want.status), 8'(got.status));
    compare_field("black_to_move", 8'(want.black_to_move), 8'(got.black_to_move));
    compare_field("castle_bits", 8'(want.castle_bits), 8'(got.castle_bits));
    compare_field("rook_file_a", 8'(want.rook_file_a), 8'(got.rook_file_a));
    compare_field("rook_file_h", 8'(want.rook_file_h), 8'(got.rook_file_h));
    compare_field("ep_valid", 8'(want.ep_valid), 8'(got.ep_valid));
    compare_field("ep_file", 8'(want.ep_file), 8'(got.ep_file));
  endtask

  // Take results with random stalls and check each one
  initial begin : result_sink
    fpp_pkg::result_item_t got;
    bit taken;
    int hold;
    hold = 0;
    result_stall <= 1'b0;
    forever begin
      @(negedge clk);
      taken = (result_valid === 1'b1) && (result_stall === 1'b0);
      got = result_item;
      @(posedge clk);
      if (taken) check_result(got);
      if (hold > 0) hold--;
      else if (idle_on) hold = pick_gap();
      result_stall <= (hold > 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Random string building

  function automatic logic [7:0] rand_case(input logic [7:0] c);
    return ($urandom_range(0, 1) == 0) ? (c & ~fpp_pkg::CASE_BIT) : c;
  endfunction

  function automatic logic [7:0] file_letter();
    logic [7:0] c;
    c = 8'($urandom_range(0, 7));
    return rand_case(fpp_pkg::CH_LO_A + c);
  endfunction

  function automatic logic [7:0] blank_char();
    logic [7:0] r;
    r = 8'($urandom_range(0, 9));
    return (r < 5) ? fpp_pkg::CH_TAB + r : fpp_pkg::CH_SPACE;
  endfunction

  task automatic add_blanks(ref logic [7:0] text[$]);
    int n;
    n = $urandom_range(0, 7);
    n = (n == 0) ? 0 : (n < 6) ? 1 : 2;
    repeat (n) text.push_back(blank_char());
  endtask

  task automatic build_position(ref logic [7:0] text[$]);
    string pieces;
    logic [7:0] c;
    int files;
    int step;
    int r;
    int half;
    bit bare;
    pieces = "pnbrqkPNBRQK";
    // half of the boards are empty, keeping strings short
    bare = ($urandom_range(0, 1) == 0);
    for (r = 7; r >= 0; r--) begin
      files = 0;
      while (files < 8) begin
        if (!bare && $urandom_range(0, 2) != 0) begin
          text.push_back(pieces[$urandom_range(0, 11)]);
          files++;
        end else begin
          step = bare ? 8 - files : $urandom_range(1, 8 - files);
          if ($urandom_range(0, 15) == 0) text.push_back(fpp_pkg::CH_ZERO);
          text.push_back(fpp_pkg::CH_ZERO + step[7:0]);
          files += step;
        end
      end
      if (r > 0 || $urandom_range(0, 7) == 0) text.push_back(fpp_pkg::CH_SLASH);
      else text.push_back(blank_char());
    end
    // side to move
    add_blanks(text);
    text.push_back(rand_case(($urandom_range(0, 1) == 0) ? fpp_pkg::CH_LO_W : fpp_pkg::CH_LO_B));
    add_blanks(text);
    // castling rights
    if ($urandom_range(0, 5) == 0) begin
      text.push_back(fpp_pkg::CH_DASH);
    end else begin
      for (half = 0; half < 2; half++) begin
        case ($urandom_range(0, 5))
          0, 1: begin
            text.push_back(($urandom_range(0, 3) == 0) ? fpp_pkg::CH_DASH :
                           rand_case(fpp_pkg::CH_LO_K));
            text.push_back(($urandom_range(0, 3) == 0) ? fpp_pkg::CH_DASH :
                           rand_case(fpp_pkg::CH_LO_Q));
          end
          2, 3: begin
            text.push_back(file_letter());
            text.push_back(file_letter());
          end
          4: begin
            text.push_back(($urandom_range(0, 1) == 0) ? fpp_pkg::CH_DASH :
                           rand_case(fpp_pkg::CH_LO_K));
            text.push_back(file_letter());
          end
          default: begin
            text.push_back(file_letter());
            text.push_back(($urandom_range(0, 1) == 0) ? fpp_pkg::CH_DASH :
                           rand_case(fpp_pkg::CH_LO_Q));
          end
        endcase
      end
    end
    add_blanks(text);
    // en-passant square
    if ($urandom_range(0, 2) == 0) begin
      text.push_back(fpp_pkg::CH_DASH);
    end else begin
      c = 8'($urandom_range(0, 7));
      text.push_back(fpp_pkg::CH_LO_A + c);
      c = 8'($urandom_range(0, 7));
      text.push_back(fpp_pkg::CH_ONE + c);
    end
    // move counters after the end are ignored
    if ($urandom_range(0, 3) == 0) begin
      text.push_back(fpp_pkg::CH_SPACE);
      text.push_back(fpp_pkg::CH_ZERO);
      text.push_back(fpp_pkg::CH_SPACE);
      text.push_back(fpp_pkg::CH_ONE);
    end
    text.push_back(fpp_pkg::CH_NUL);
  endtask

  // ---------------------------------------------------------------------------
  // Tests

  task automatic test_idle_and_done();
    // bytes before any start are dropped
    send_byte(fpp_pkg::CH_LO_K, 1'b0);
    send_byte(fpp_pkg::CH_NUL, 1'b0);
    // a zero digit adds no file, then the string ends early
    send_text("0", 1'b1);
    // bytes after the outcome are dropped
    send_byte(fpp_pkg::CH_LO_P, 1'b0);
  endtask

  task automatic test_rank_errors();
    send_text("9", 1'b0);
    send_text("8p", 1'b0);
    send_text("8x", 1'b0);
    send_text("7/", 1'b0);
  endtask

  task automatic test_full_position();
    // restart mid-rank, then a full string with every kind and the corner squares
    send_text("p3", 1'b0);
    send_text("pnbrqk1p/8/8/8/8/8/8/PNBRQK1P\tb Hb-a h8", 1'b1);
    send_byte(fpp_pkg::CH_SPACE, 1'b0);
  endtask

  task automatic test_random_positions();
    logic [7:0] text[$];
    logic [7:0] noise;
    int i;
    int cut;
    int start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      text.delete();
      idle_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          noise = 8'($urandom_range(0, 255));
          text.push_back(noise);
        end
      end else begin
        build_position(text);
        cut = $urandom_range(1, text.size() - 1);
        case ($urandom_range(0, 7))
          0: text[cut] = 8'($urandom_range(0, 255));
          1: text[cut] = fpp_pkg::CH_NUL;
          default: ;
        endcase
      end
      for (i = 0; i < text.size(); i++) send_byte(text[i], i == 0);
      strings_sent++;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    pp_phase = P_IDLE;
    start_position();
    rst <= 1'b1;
    byte_valid <= 1'b0;
    byte_item <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_idle_and_done();
    test_rank_errors();
    test_full_position();
    test_random_positions();

    // drain outstanding results
    byte_valid <= 1'b0;
    while (predicted_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Parsed %0d bytes over %0d strings, with restarts and ignored bytes.",
             bytes_sent, strings_sent);
    $display("Checked %0d piece placements and %0d parse outcomes.",
             placements_seen, outcomes_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== fen_position_parser_core.f =====
rtl/core/fpp_pkg.sv
rtl/core/fpp_front.sv
rtl/core/fpp_queue.sv
rtl/core/fpp_back.sv
rtl/core/fen_position_parser_core.sv
verif/fen_position_parser_core_test.sv
